// ===== design/hps_pkg.sv =====
// shared types and constants of the heater pid supervisor
`default_nettype none

package hps_pkg;

  // input item kinds as carried on in_tuser
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  // fault codes written by the supervisor
  localparam logic [2:0] FAULT_OVERHEAT   = 3'd1;
  localparam logic [2:0] FAULT_SENSOR     = 3'd2;
  localparam logic [2:0] FAULT_AMBIENT    = 3'd3;
  localparam logic [2:0] FAULT_REGULATION = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_PROP        = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG       = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV       = 3'd2;
  localparam logic [2:0] REG_OVERHEAT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_AMBIENT_LEVEL    = 3'd4;
  localparam logic [2:0] REG_REGULATION_BAND  = 3'd5;
  localparam logic [2:0] REG_AMBIENT_TICKS    = 3'd6;
  localparam logic [2:0] REG_REGULATION_TICKS = 3'd7;

  localparam int CFG_AW    = 5;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int HYST_W    = 5;

  typedef enum logic [1:0] {
    HS_OFF       = 2'd0,
    HS_HEATING   = 2'd1,
    HS_REGULATED = 2'd2,
    HS_SHUTDOWN  = 2'd3
  } heater_state_t;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_EVAL = 2'd1,
    SEQ_MUL  = 2'd2,
    SEQ_SUM  = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [15:0] gain_prop;
    logic [15:0] gain_integ;
    logic [15:0] gain_deriv;
    logic [15:0] overheat_limit;
    logic [15:0] ambient_level;
    logic [14:0] regulation_band;
    logic [15:0] ambient_ticks;
    logic [15:0] regulation_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] temperature;
    logic [14:0] target;
    logic        off_shutdown;
    logic [2:0]  stop_code;
  } queue_item_t;

  typedef struct packed {
    logic        blink;
    logic [2:0]  fault_code;
    logic [1:0]  heater_status;
    logic [9:0]  duty;
  } result_t;

endpackage

`default_nettype wire

// ===== design/hps_cfg_regs.sv =====
// configuration register file with apb-style access
`default_nettype none

module hps_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [hps_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output hps_pkg::cfg_t                    cfg
);

  hps_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx        = cfg_paddr[hps_pkg::CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop        <= 16'd256;
      cfg_r.gain_integ       <= 16'd0;
      cfg_r.gain_deriv       <= 16'd0;
      cfg_r.overheat_limit   <= 16'd4800;
      cfg_r.ambient_level    <= 16'd640;
      cfg_r.regulation_band  <= 15'd48;
      cfg_r.ambient_ticks    <= 16'd900;
      cfg_r.regulation_ticks <= 16'd3000;
    end else if (wr_en) begin
      case (idx)
        hps_pkg::REG_GAIN_PROP:        cfg_r.gain_prop        <= cfg_pwdata[15:0];
        hps_pkg::REG_GAIN_INTEG:       cfg_r.gain_integ       <= cfg_pwdata[15:0];
        hps_pkg::REG_GAIN_DERIV:       cfg_r.gain_deriv       <= cfg_pwdata[15:0];
        hps_pkg::REG_OVERHEAT_LIMIT:   cfg_r.overheat_limit   <= cfg_pwdata[15:0];
        hps_pkg::REG_AMBIENT_LEVEL:    cfg_r.ambient_level    <= cfg_pwdata[15:0];
        hps_pkg::REG_REGULATION_BAND:  cfg_r.regulation_band  <= cfg_pwdata[14:0];
        hps_pkg::REG_AMBIENT_TICKS:    cfg_r.ambient_ticks    <= cfg_pwdata[15:0];
        hps_pkg::REG_REGULATION_TICKS: cfg_r.regulation_ticks <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hps_pkg::REG_GAIN_PROP:        cfg_prdata = {16'd0, cfg_r.gain_prop};
      hps_pkg::REG_GAIN_INTEG:       cfg_prdata = {16'd0, cfg_r.gain_integ};
      hps_pkg::REG_GAIN_DERIV:       cfg_prdata = {16'd0, cfg_r.gain_deriv};
      hps_pkg::REG_OVERHEAT_LIMIT:   cfg_prdata = {16'd0, cfg_r.overheat_limit};
      hps_pkg::REG_AMBIENT_LEVEL:    cfg_prdata = {16'd0, cfg_r.ambient_level};
      hps_pkg::REG_REGULATION_BAND:  cfg_prdata = {17'd0, cfg_r.regulation_band};
      hps_pkg::REG_AMBIENT_TICKS:    cfg_prdata = {16'd0, cfg_r.ambient_ticks};
      hps_pkg::REG_REGULATION_TICKS: cfg_prdata = {16'd0, cfg_r.regulation_ticks};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hps_front.sv =====
// front end: accepts input beats, classifies them and queues them
`default_nettype none

module hps_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [39:0]          in_tdata,
  input  wire logic [1:0]           in_tuser,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output hps_pkg::queue_item_t      q_item
);

  hps_pkg::queue_item_t               slot_r [hps_pkg::Q_DEPTH];
  logic [hps_pkg::Q_PTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [hps_pkg::Q_PTR_W:0]          count_r;
  hps_pkg::queue_item_t               entry;
  logic                               push, pop;

  always_comb begin
    entry.temperature  = in_tdata[15:0];
    entry.target       = in_tdata[30:16];
    entry.off_shutdown = in_tdata[31];
    entry.stop_code    = in_tdata[34:32];
    case (in_tuser)
      hps_pkg::MODE_TICK: entry.kind = hps_pkg::KIND_TICK;
      hps_pkg::MODE_ON:   entry.kind = hps_pkg::KIND_ON;
      hps_pkg::MODE_OFF:  entry.kind = hps_pkg::KIND_OFF;
      default:            entry.kind = hps_pkg::KIND_NONE;
    endcase
  end

  assign in_tready = (count_r != (hps_pkg::Q_PTR_W+1)'(hps_pkg::Q_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= entry;
  end

endmodule

`default_nettype wire

// ===== design/hps_back.sv =====
// back end: supervisor checks, pid step, channel state and result register
`default_nettype none

module hps_back #(
  parameter int DUTY_MAX      = 1023,
  parameter int HYST_LIMIT    = 10,
  parameter int BAD_LIMIT     = 5,
  parameter int ERR_EPSILON   = 2,
  parameter int INIT_INTEGRAL = 0,
  parameter int ABS_ZERO_Q4   = -4370
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hps_pkg::cfg_t        cfg,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire hps_pkg::queue_item_t q_item,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output hps_pkg::result_t          out_res
);

  localparam int DW = $clog2(DUTY_MAX + 1);
  localparam int HW = hps_pkg::HYST_W;

  hps_pkg::seq_state_t     seq_r, seq_nxt;
  hps_pkg::queue_item_t    item_r;

  hps_pkg::heater_state_t  hmode_r, hmode_nxt;
  logic [2:0]              code_r, code_nxt;
  logic [14:0]             setpt_r, setpt_nxt;
  logic [HW-1:0]           hyst_r, hyst_nxt;
  logic [7:0]              bad_r, bad_nxt;
  logic [15:0]             timer_r, timer_nxt;
  logic signed [31:0]      integ_r, integ_nxt;
  logic signed [17:0]      prev_err_r, prev_err_nxt;
  logic [DW-1:0]           duty_r, duty_nxt;
  logic [1:0]              tog_r, tog_nxt;
  logic                    blink_r, blink_nxt;

  // per-tick working values, held from eval through sum
  logic signed [17:0]      err_r, deriv_r;
  logic [16:0]             mag_r;
  logic                    below_amb_r, below_sp_r;
  logic signed [34:0]      prod_p_r, prod_d_r;
  logic signed [48:0]      prod_i_r;

  logic                    out_valid_r;
  hps_pkg::result_t        out_res_r;
  logic                    out_free, commit;

  logic signed [15:0]      temp_s;
  logic signed [17:0]      temp_ext, sp_s, err_c, deriv_c;
  logic [16:0]             mag_c;
  logic signed [32:0]      sum_c;
  logic signed [31:0]      integ_sat;
  logic                    overheat, bad_read, bad_trip, integ_en;
  logic [7:0]              bad_inc;
  logic signed [50:0]      acc_c;
  logic [38:0]             acc_sh;
  logic [DW-1:0]           duty_calc;
  logic [15:0]             timer_inc;
  logic [HW:0]             hyst_up;

  assign q_ready    = (seq_r == hps_pkg::SEQ_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  // eval stage arithmetic
  always_comb begin
    temp_s   = item_r.temperature;
    temp_ext = {{2{temp_s[15]}}, temp_s};
    sp_s     = {3'b000, setpt_r};
    err_c    = sp_s - temp_ext;
    mag_c    = err_c[17] ? 17'(-err_c) : err_c[16:0];
    deriv_c  = err_c - prev_err_r;
    sum_c    = {integ_r[31], integ_r} + {{15{err_c[17]}}, err_c};
    if (sum_c[32] != sum_c[31]) begin
      integ_sat = sum_c[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_sat = sum_c[31:0];
    end
    overheat = (temp_s > $signed(cfg.overheat_limit));
    bad_read = (int'(temp_s) < ABS_ZERO_Q4);
    bad_inc  = (bad_r == 8'hff) ? bad_r : bad_r + 8'd1;
    bad_trip = (int'(bad_inc) > BAD_LIMIT);
    integ_en = (int'(mag_c) > ERR_EPSILON) && (int'(duty_r) < DUTY_MAX);
  end

  // sum stage arithmetic
  always_comb begin
    acc_c  = 51'(prod_p_r) + 51'(prod_i_r) + 51'(prod_d_r);
    acc_sh = acc_c[50:12];
    if (acc_c[50]) begin
      duty_calc = '0;
    end else if (acc_sh > 39'(DUTY_MAX)) begin
      duty_calc = DW'(DUTY_MAX);
    end else begin
      duty_calc = acc_sh[DW-1:0];
    end
    timer_inc = (timer_r == 16'hffff) ? timer_r : timer_r + 16'd1;
    hyst_up   = {1'b0, hyst_r} + (HW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= hps_pkg::SEQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_comb begin
    seq_nxt      = seq_r;
    commit       = 1'b0;
    hmode_nxt    = hmode_r;
    code_nxt     = code_r;
    setpt_nxt    = setpt_r;
    hyst_nxt     = hyst_r;
    bad_nxt      = bad_r;
    timer_nxt    = timer_r;
    integ_nxt    = integ_r;
    prev_err_nxt = prev_err_r;
    duty_nxt     = duty_r;
    tog_nxt      = tog_r;
    blink_nxt    = blink_r;
    case (seq_r)
      hps_pkg::SEQ_IDLE: begin
        if (q_valid) seq_nxt = hps_pkg::SEQ_EVAL;
      end
      hps_pkg::SEQ_EVAL: begin
        case (item_r.kind)
          hps_pkg::KIND_ON: begin
            if (out_free) begin
              if (hmode_r != hps_pkg::HS_HEATING && hmode_r != hps_pkg::HS_REGULATED) begin
                setpt_nxt    = item_r.target;
                integ_nxt    = 32'(INIT_INTEGRAL);
                prev_err_nxt = '0;
                duty_nxt     = '0;
                hyst_nxt     = '0;
                bad_nxt      = '0;
                timer_nxt    = '0;
                hmode_nxt    = hps_pkg::HS_HEATING;
              end
              commit  = 1'b1;
              seq_nxt = hps_pkg::SEQ_IDLE;
            end
          end
          hps_pkg::KIND_OFF: begin
            if (out_free) begin
              duty_nxt  = '0;
              hmode_nxt = item_r.off_shutdown ? hps_pkg::HS_SHUTDOWN : hps_pkg::HS_OFF;
              code_nxt  = item_r.stop_code;
              commit    = 1'b1;
              seq_nxt   = hps_pkg::SEQ_IDLE;
            end
          end
          hps_pkg::KIND_TICK: begin
            if (hmode_r == hps_pkg::HS_OFF || hmode_r == hps_pkg::HS_SHUTDOWN) begin
              if (out_free) begin
                commit  = 1'b1;
                seq_nxt = hps_pkg::SEQ_IDLE;
              end
            end else if (overheat) begin
              if (out_free) begin
                duty_nxt  = '0;
                hmode_nxt = hps_pkg::HS_SHUTDOWN;
                code_nxt  = hps_pkg::FAULT_OVERHEAT;
                commit    = 1'b1;
                seq_nxt   = hps_pkg::SEQ_IDLE;
              end
            end else if (bad_read) begin
              if (out_free) begin
                bad_nxt = bad_inc;
                if (bad_trip) begin
                  duty_nxt  = '0;
                  hmode_nxt = hps_pkg::HS_SHUTDOWN;
                  code_nxt  = hps_pkg::FAULT_SENSOR;
                end
                commit  = 1'b1;
                seq_nxt = hps_pkg::SEQ_IDLE;
              end
            end else begin
              // pid path: integrator and error history update now, duty in sum
              bad_nxt      = '0;
              if (integ_en) integ_nxt = integ_sat;
              prev_err_nxt = err_c;
              seq_nxt      = hps_pkg::SEQ_MUL;
            end
          end
          default: begin
            if (out_free) begin
              commit  = 1'b1;
              seq_nxt = hps_pkg::SEQ_IDLE;
            end
          end
        endcase
      end
      hps_pkg::SEQ_MUL: begin
        seq_nxt = hps_pkg::SEQ_SUM;
      end
      hps_pkg::SEQ_SUM: begin
        if (out_free) begin
          commit   = 1'b1;
          seq_nxt  = hps_pkg::SEQ_IDLE;
          duty_nxt = duty_calc;
          if (hmode_r == hps_pkg::HS_HEATING) begin
            timer_nxt = timer_inc;
          end
          if (hmode_r == hps_pkg::HS_HEATING && below_amb_r &&
              timer_inc > cfg.ambient_ticks) begin
            duty_nxt  = '0;
            hmode_nxt = hps_pkg::HS_SHUTDOWN;
            code_nxt  = hps_pkg::FAULT_AMBIENT;
          end else if (hmode_r == hps_pkg::HS_HEATING && below_sp_r &&
                       timer_inc > cfg.regulation_ticks) begin
            duty_nxt  = '0;
            hmode_nxt = hps_pkg::HS_SHUTDOWN;
            code_nxt  = hps_pkg::FAULT_REGULATION;
          end else begin
            // hysteresis on the in-band count
            if (mag_r <= {2'b00, cfg.regulation_band}) begin
              if (hyst_up > (HW+1)'(HYST_LIMIT)) begin
                hyst_nxt  = HW'(HYST_LIMIT);
                hmode_nxt = hps_pkg::HS_REGULATED;
              end else begin
                hyst_nxt = hyst_up[HW-1:0];
              end
            end else begin
              if (hyst_r <= HW'(1)) begin
                hyst_nxt  = '0;
                timer_nxt = '0;
                hmode_nxt = hps_pkg::HS_HEATING;
              end else begin
                hyst_nxt = hyst_r - HW'(1);
              end
            end
            if (hmode_nxt != hps_pkg::HS_REGULATED) begin
              tog_nxt = tog_r + 2'd1;
              if (tog_r == 2'd3) blink_nxt = !blink_r;
            end
          end
        end
      end
      default: seq_nxt = hps_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmode_r     <= hps_pkg::HS_OFF;
      code_r      <= '0;
      setpt_r     <= '0;
      hyst_r      <= '0;
      bad_r       <= '0;
      timer_r     <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      duty_r      <= '0;
      tog_r       <= '0;
      blink_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hmode_r    <= hmode_nxt;
      code_r     <= code_nxt;
      setpt_r    <= setpt_nxt;
      hyst_r     <= hyst_nxt;
      bad_r      <= bad_nxt;
      timer_r    <= timer_nxt;
      integ_r    <= integ_nxt;
      prev_err_r <= prev_err_nxt;
      duty_r     <= duty_nxt;
      tog_r      <= tog_nxt;
      blink_r    <= blink_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) item_r <= q_item;
    if (seq_r == hps_pkg::SEQ_EVAL) begin
      err_r       <= err_c;
      deriv_r     <= deriv_c;
      mag_r       <= mag_c;
      below_amb_r <= (temp_s < $signed(cfg.ambient_level));
      below_sp_r  <= (temp_ext < sp_s);
    end
    if (seq_r == hps_pkg::SEQ_MUL) begin
      prod_p_r <= $signed({1'b0, cfg.gain_prop}) * err_r;
      prod_i_r <= $signed({1'b0, cfg.gain_integ}) * integ_r;
      prod_d_r <= $signed({1'b0, cfg.gain_deriv}) * deriv_r;
    end
    if (commit) begin
      out_res_r.duty          <= 10'(duty_nxt);
      out_res_r.heater_status <= hmode_nxt;
      out_res_r.fault_code    <= code_nxt;
      out_res_r.blink         <= blink_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/heater_pid_supervisor_unit.sv =====
// top level of the heater pid supervisor
//
//  port group  dir  handshake          contents
//  in_*        in   tvalid/tready      one command or temperature tick per beat
//  out_*       out  tvalid/tready      channel state after each command
//  cfg_*       in   psel/penable/pwr   gains, limits and timeouts
//
// a tick passes through the sequencer steps dequeue, check, multiply,
// sum and commit; the three gain multiplies share one registered stage.
// turn on, turn off, ignored items, overheat and sensor trips commit in the check step;
// ambient and regulation timeouts are found in the sum step of a tick.
// a 4-beat input queue keeps accepting while the back end runs or the
// result waits; a stalled result register holds the sequencer in place.
// rst_n is synchronous and active low and clears all channel state.
`default_nettype none

module heater_pid_supervisor_unit #(
  parameter int DUTY_MAX      = 1023,
  parameter int HYST_LIMIT    = 10,
  parameter int BAD_LIMIT     = 5,
  parameter int ERR_EPSILON   = 2,
  parameter int INIT_INTEGRAL = 0,
  parameter int ABS_ZERO_Q4   = -4370
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // temperature[15:0], target[30:16], off_shutdown[31], stop_code[34:32], zero fill
  input  wire logic [39:0]                 in_tdata,
  // mode[1:0]
  input  wire logic [1:0]                  in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // duty[9:0], heater_status[11:10], fault_code[14:12], blink[15]
  output logic [15:0]                      out_tdata,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [hps_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  hps_pkg::cfg_t         cfg;
  hps_pkg::queue_item_t  q_item;
  hps_pkg::result_t      res;
  logic                  q_valid, q_ready;

  hps_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  hps_back #(
    .DUTY_MAX      (DUTY_MAX),
    .HYST_LIMIT    (HYST_LIMIT),
    .BAD_LIMIT     (BAD_LIMIT),
    .ERR_EPSILON   (ERR_EPSILON),
    .INIT_INTEGRAL (INIT_INTEGRAL),
    .ABS_ZERO_Q4   (ABS_ZERO_Q4)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the heater pid supervisor unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUTY_TOP     = 1023;
  localparam int HYST_TOP     = 10;
  localparam int BAD_TRIP     = 5;
  localparam int ERR_DEADBAND = 2;
  localparam int INTEG_INIT   = 0;
  localparam int ABS_ZERO     = -4370;

  localparam int LONG_HOLD  = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam longint INTEG_HI = 64'sd2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [hps_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  heater_pid_supervisor_unit #(
    .DUTY_MAX(DUTY_TOP),
    .HYST_LIMIT(HYST_TOP),
    .BAD_LIMIT(BAD_TRIP),
    .ERR_EPSILON(ERR_DEADBAND),
    .INIT_INTEGRAL(INTEG_INIT),
    .ABS_ZERO_Q4(ABS_ZERO)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // channel settings as last written
  int k_p = 256;
  int k_i = 0;
  int k_d = 0;
  logic [15:0] lim_hot = 16'd4800;
  logic [15:0] lvl_amb = 16'd640;
  int band_q = 48;
  int amb_ticks = 900;
  int reg_ticks = 3000;

  // channel state
  hps_pkg::heater_state_t hs = hps_pkg::HS_OFF;
  logic [2:0] code_q = 3'd0;
  int sp_q = 0;
  int hyst_q = 0;
  int bad_q = 0;
  int tmr_q = 0;
  int integ_q = 0;
  int prev_q = 0;
  int duty_q = 0;
  int tog_q = 0;
  logic blink_q = 1'b0;

  hps_pkg::result_t want_status_q[$];
  hps_pkg::result_t got_status;
  hps_pkg::result_t want_status;
  int n_fail = 0;
  int n_beats = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  bit tx_gaps;
  bit rx_stalls;
  bit hold_req;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic trip(input logic [2:0] fault);
    duty_q = 0;
    hs = hps_pkg::HS_SHUTDOWN;
    code_q = fault;
  endtask

  task automatic advance_tick(input int t);
    int e, mag, d, hc, hot, amb;
    longint s, acc;
    if (hs == hps_pkg::HS_OFF || hs == hps_pkg::HS_SHUTDOWN) return;
    hot = $signed(lim_hot);
    amb = $signed(lvl_amb);
    if (t > hot) begin
      trip(hps_pkg::FAULT_OVERHEAT);
      return;
    end
    if (t < ABS_ZERO) begin
      if (bad_q < 255) bad_q++;
      if (bad_q > BAD_TRIP) trip(hps_pkg::FAULT_SENSOR);
      return;
    end
    bad_q = 0;

    e = sp_q - t;
    mag = (e < 0) ? -e : e;
    // integral frozen inside the deadband and while the output is pinned
    if (mag > ERR_DEADBAND && duty_q < DUTY_TOP) begin
      s = longint'(integ_q) + e;
      if (s > INTEG_HI) s = INTEG_HI;
      if (s < INTEG_LO) s = INTEG_LO;
      integ_q = int'(s);
    end
    d = e - prev_q;
    acc = longint'(k_p) * e + longint'(k_i) * integ_q + longint'(k_d) * d;
    if (acc < 0) begin
      duty_q = 0;
    end else begin
      acc = acc >>> 12;
      duty_q = (acc > DUTY_TOP) ? DUTY_TOP : int'(acc);
    end
    prev_q = e;

    if (hs == hps_pkg::HS_HEATING) begin
      if (tmr_q < 65535) tmr_q++;
      if (t < amb && tmr_q > amb_ticks) begin
        trip(hps_pkg::FAULT_AMBIENT);
        return;
      end
      if (t < sp_q && tmr_q > reg_ticks) begin
        trip(hps_pkg::FAULT_REGULATION);
        return;
      end
    end

    hc = hyst_q;
    if (mag <= band_q) begin
      hc++;
      if (hc > HYST_TOP) begin
        hc = HYST_TOP;
        hs = hps_pkg::HS_REGULATED;
      end
    end else begin
      hc--;
      if (hc <= 0) begin
        hc = 0;
        tmr_q = 0;
        hs = hps_pkg::HS_HEATING;
      end
    end
    hyst_q = hc;

    if (hs != hps_pkg::HS_REGULATED) begin
      tog_q++;
      if (tog_q > 3) begin
        tog_q = 0;
        blink_q = ~blink_q;
      end
    end
  endtask

  task automatic update_channel(input logic [1:0] kind, input logic [15:0] temp,
                                input logic [14:0] tgt, input logic offs,
                                input logic [2:0] code);
    hps_pkg::result_t r;
    case (kind)
      hps_pkg::MODE_TICK: advance_tick($signed(temp));
      hps_pkg::MODE_ON: begin
        if (hs != hps_pkg::HS_HEATING && hs != hps_pkg::HS_REGULATED) begin
          sp_q = tgt;
          integ_q = INTEG_INIT;
          prev_q = 0;
          duty_q = 0;
          hyst_q = 0;
          bad_q = 0;
          tmr_q = 0;
          hs = hps_pkg::HS_HEATING;
        end
      end
      hps_pkg::MODE_OFF: begin
        duty_q = 0;
        hs = offs ? hps_pkg::HS_SHUTDOWN : hps_pkg::HS_OFF;
        code_q = code;
      end
      default: ;
    endcase
    r.duty = duty_q[9:0];
    r.heater_status = hs;
    r.fault_code = code_q;
    r.blink = blink_q;
    want_status_q.push_back(r);
  endtask

  // called at a falling edge; valid stays up after the beat until the next gap or drain
  task automatic send_item(input logic [1:0] kind, input logic [15:0] temp,
                           input logic [14:0] tgt, input logic offs,
                           input logic [2:0] code);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 1) == 1) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {5'b0, code, offs, tgt, temp};
    do @(posedge clk); while (!in_tready);
    update_channel(kind, temp, tgt, offs, code);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick(input int t);
    send_item(hps_pkg::MODE_TICK, t[15:0], 15'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic send_on(input int sp);
    send_item(hps_pkg::MODE_ON, 16'($urandom), sp[14:0], 1'($urandom), 3'($urandom));
  endtask

  task automatic send_off(input logic offs, input logic [2:0] code);
    send_item(hps_pkg::MODE_OFF, 16'($urandom), 15'($urandom), offs, code);
  endtask

  task automatic send_noise();
    send_item(hps_pkg::KIND_NONE, 16'($urandom), 15'($urandom), 1'($urandom),
              3'($urandom));
  endtask

  task automatic wait_results_done();
    in_tvalid = 1'b0;
    while (want_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {16'h0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      hps_pkg::REG_GAIN_PROP:        k_p = val;
      hps_pkg::REG_GAIN_INTEG:       k_i = val;
      hps_pkg::REG_GAIN_DERIV:       k_d = val;
      hps_pkg::REG_OVERHEAT_LIMIT:   lim_hot = val;
      hps_pkg::REG_AMBIENT_LEVEL:    lvl_amb = val;
      hps_pkg::REG_REGULATION_BAND:  band_q = val[14:0];
      hps_pkg::REG_AMBIENT_TICKS:    amb_ticks = val;
      hps_pkg::REG_REGULATION_TICKS: reg_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic program_all(input logic [15:0] gp, input logic [15:0] gi,
                             input logic [15:0] gd, input logic [15:0] hot,
                             input logic [15:0] amb, input logic [15:0] band,
                             input logic [15:0] at, input logic [15:0] rt);
    wait_results_done();
    cfg_write(hps_pkg::REG_GAIN_PROP, gp);
    cfg_write(hps_pkg::REG_GAIN_INTEG, gi);
    cfg_write(hps_pkg::REG_GAIN_DERIV, gd);
    cfg_write(hps_pkg::REG_OVERHEAT_LIMIT, hot);
    cfg_write(hps_pkg::REG_AMBIENT_LEVEL, amb);
    cfg_write(hps_pkg::REG_REGULATION_BAND, band);
    cfg_write(hps_pkg::REG_AMBIENT_TICKS, at);
    cfg_write(hps_pkg::REG_REGULATION_TICKS, rt);
  endtask

  function automatic int near_setpoint(input int sp);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return sp + int'($urandom_range(0, 80)) - 40;
    if (r < 85) return sp + int'($urandom_range(0, 4000)) - 2000;
    if (r < 95) return int'($signed(16'($urandom)));
    return ABS_ZERO - 1 - int'($urandom_range(0, 28397));
  endfunction

  // turn on, a run of ticks around the setpoint with some noise, mostly a turn off
  task automatic run_sessions(input int count);
    int stop_at, n, r, sp;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      sp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
      send_on(sp);
      n = $urandom_range(4, 40);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_noise();
        else if (r < 5) send_on($urandom_range(0, 32767));
        else if (r < 7) send_off(1'($urandom), 3'($urandom));
        else send_tick(near_setpoint(sp));
      end
      if ($urandom_range(0, 9) < 7) send_off(1'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_item(hps_pkg::KIND_NONE, 16'hFFFF, 15'h7FFF, 1'b1, 3'h7);
    send_item(hps_pkg::MODE_TICK, 16'h0000, 15'h0000, 1'b0, 3'h0);   // ignored while off
    send_item(hps_pkg::MODE_ON, 16'h0000, 15'd1600, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_ON, 16'h0000, 15'd0, 1'b0, 3'h0);        // ignored while heating
    send_item(hps_pkg::MODE_TICK, 16'(ABS_ZERO), 15'h0, 1'b0, 3'h0);  // lowest valid reading
    send_item(hps_pkg::MODE_TICK, 16'h8000, 15'h0, 1'b0, 3'h0);
    repeat (BAD_TRIP) send_item(hps_pkg::MODE_TICK, 16'(ABS_ZERO - 1), 15'h0, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_TICK, 16'd1600, 15'h0, 1'b0, 3'h0);      // ignored while shut down
    send_item(hps_pkg::MODE_ON, 16'h0000, 15'h7FFF, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_TICK, 16'd4800, 15'h0, 1'b0, 3'h0);      // at the limit, pinned
    send_item(hps_pkg::MODE_TICK, 16'd4700, 15'h0, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_TICK, 16'h7FFF, 15'h0, 1'b0, 3'h0);      // overheat
    send_item(hps_pkg::MODE_OFF, 16'h0000, 15'h0, 1'b0, 3'h7);
    send_item(hps_pkg::MODE_ON, 16'h0000, 15'd0, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_TICK, 16'd0, 15'h0, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_TICK, 16'hFFF0, 15'h0, 1'b0, 3'h0);
    send_item(hps_pkg::MODE_OFF, 16'hFFFF, 15'h7FFF, 1'b1, 3'h0);
    send_item(hps_pkg::KIND_NONE, 16'h0000, 15'h0, 1'b0, 3'h0);
  endtask

  task automatic test_register_settings();
    program_all(16'd256, 16'd0, 16'd0, 16'd4800, 16'd640, 16'd48, 16'd900, 16'd3000);
    run_sessions(130);
    program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                16'hFFFF, 16'hFFFF);
    run_sessions(130);
    program_all(16'h0, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0);
    run_sessions(130);
    program_all(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 64)),
                16'($urandom_range(0, 1024)), 16'd4800, 16'(16 * $urandom_range(20, 60)),
                16'($urandom_range(8, 80)), 16'($urandom_range(0, 20)),
                16'($urandom_range(2, 15)));
    run_sessions(130);
    program_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_sessions(130);
  endtask

  task automatic test_output_hold_off();
    program_all(16'd512, 16'd4, 16'd128, 16'd4800, 16'd640, 16'd48, 16'd900, 16'd3000);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_req = 1'b1;
    send_on(1000);
    repeat (30) send_tick(near_setpoint(1000));
    // sender waits for every result before going on
    wait_results_done();
    run_sessions(15);
  endtask

  task automatic test_random_traffic();
    run_sessions(110);
    wait_results_done();
    run_sessions(110);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata;
      n_beats++;
      if (want_status_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("beat %0d with nothing expected: duty %0d status %0d code %0d blink %0d",
                   n_beats, got_status.duty, got_status.heater_status,
                   got_status.fault_code, got_status.blink);
      end else begin
        want_status = want_status_q.pop_front();
        if (got_status.duty !== want_status.duty ||
            got_status.heater_status !== want_status.heater_status ||
            got_status.fault_code !== want_status.fault_code ||
            got_status.blink !== want_status.blink) begin
          n_fail++;
          if (n_fail <= 10)
            $display("beat %0d: expected duty/status/code/blink %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     n_beats, want_status.duty, want_status.heater_status,
                     want_status.fault_code, want_status.blink, got_status.duty,
                     got_status.heater_status, got_status.fault_code, got_status.blink);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("heater_pid_supervisor_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_settings();
    test_output_hold_off();
    test_random_traffic();

    wait_results_done();
    repeat (20) @(negedge clk);
    if (n_fail == 0)
      $display("heater_pid_supervisor_unit: match");
    else
      $display("heater_pid_supervisor_unit: mismatch");
    $finish;
  end

endmodule
